@@ rtl/tcw_pkg.sv @@
// Shared types, constants and codes of the text console character writer.
`default_nettype none
package tcw_pkg;

   localparam int DEF_COLUMNS  = 80;
   localparam int DEF_ROWS     = 25;
   localparam int DEF_TAB_STOP = 8;

   localparam int CMD_W        = 2;
   localparam int REQ_TDATA_W  = 32;
   localparam int RSP_TDATA_W  = 40;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 8;
   localparam int CELL_W       = 16;

   localparam logic [CMD_W-1:0] CMD_PRINT      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET_CURSOR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ_CELL  = 2'd2;

   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;

   localparam logic [CSR_INDEX_W-1:0] CSR_FILL_CHAR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILL_ATTR = 1'd1;

   localparam logic [7:0] FILL_CHAR_RESET = 8'd32;
   localparam logic [7:0] FILL_ATTR_RESET = 8'd7;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [7:0]       ch;
      logic [3:0]       fg;
      logic [3:0]       bg;
      logic [6:0]       col;
      logic [4:0]       row;
   } req_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [10:0] cursor_address;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
   } rsp_type;

   typedef struct packed {
      logic [7:0] fill_char;
      logic [7:0] fill_attr;
   } cfg_type;

endpackage
`default_nettype wire

@@ rtl/tcw_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ rtl/tcw_seq.sv @@
// Sequencer: cursor, control codes, blanking, scrolling and clearing of the cell store.
`default_nettype none
module tcw_seq #(
   parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS     = tcw_pkg::DEF_ROWS,
   parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP,
   parameter int AW       = $clog2(COLUMNS * ROWS)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire tcw_pkg::req_type            req,
   input  wire tcw_pkg::cfg_type            cfg,
   input  wire logic                        out_free,
   output logic                             rsp_valid,
   output tcw_pkg::rsp_type                 rsp,
   output logic                             ram_we,
   output logic [AW-1:0]                    ram_waddr,
   output logic [tcw_pkg::CELL_W-1:0]       ram_wdata,
   output logic                             ram_re,
   output logic [AW-1:0]                    ram_raddr,
   input  wire logic [tcw_pkg::CELL_W-1:0]  ram_rdata
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int CW    = $clog2(COLUMNS + 1);
   localparam int RW    = $clog2(ROWS);
   localparam int TD    = 2 ** CW;

   function automatic logic [TD-1:0] build_stops();
      logic [TD-1:0] t;
      for (int i = 0; i < TD; i++) begin
         t[i] = ((i % TAB_STOP) == 0);
      end
      return t;
   endfunction

   localparam logic [TD-1:0] TAB_STOPS = build_stops();

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
      cell_addr = AW'(r) * AW'(COLUMNS) + AW'(c);
   endfunction

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_READ, S_BLANK, S_BACK,
      S_WRAP, S_SCR_RD, S_SCR_WR, S_FILL, S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     line_ff, line_in;
   logic [AW-1:0]     idx_ff, idx_in;
   req_type           item_ff, item_in;
   logic              tab_ff, tab_in;
   logic [CELL_W-1:0] cell_ff, cell_in;

   logic [AW-1:0] cur_addr;
   logic [7:0]    col_wide;
   logic [5:0]    row_wide;
   logic [CW-1:0] col_sat;
   logic [RW-1:0] row_sat;
   logic [CW-1:0] next_col;
   logic [7:0]    item_attr;

   assign cur_addr  = cell_addr(line_ff, col_ff);
   assign col_wide  = {1'b0, item_ff.col};
   assign row_wide  = {1'b0, item_ff.row};
   assign col_sat   = (col_wide > 8'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(item_ff.col);
   assign row_sat   = (row_wide > 6'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(item_ff.row);
   assign next_col  = CW'(col_ff + 1'b1);
   assign item_attr = {item_ff.bg, item_ff.fg};

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      line_in   = line_ff;
      idx_in    = idx_ff;
      item_in   = item_ff;
      tab_in    = tab_ff;
      cell_in   = cell_ff;
      ram_we    = 1'b0;
      ram_waddr = cur_addr;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = cur_addr;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            idx_in    = AW'(idx_ff + 1'b1);
            if (idx_ff == AW'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cell_in  = '0;
            state_in = S_DONE;
            case (item_ff.cmd)
               CMD_PRINT: begin
                  case (item_ff.ch)
                     CH_RETURN: begin
                        col_in = '0;
                     end
                     CH_NEWLINE: begin
                        tab_in   = 1'b0;
                        state_in = S_BLANK;
                     end
                     CH_TAB: begin
                        tab_in   = 1'b1;
                        state_in = S_BLANK;
                     end
                     CH_BACKSPACE: begin
                        if (col_ff != '0 || line_ff != '0) begin
                           state_in = S_BACK;
                           if (col_ff == '0) begin
                              col_in  = CW'(COLUMNS - 1);
                              line_in = RW'(line_ff - 1'b1);
                           end else begin
                              col_in = CW'(col_ff - 1'b1);
                           end
                        end
                     end
                     default: begin
                        ram_we    = 1'b1;
                        ram_wdata = {item_attr, item_ff.ch};
                        col_in    = next_col;
                        state_in  = S_WRAP;
                     end
                  endcase
               end
               CMD_SET_CURSOR: begin
                  col_in  = col_sat;
                  line_in = row_sat;
               end
               CMD_READ_CELL: begin
                  ram_re    = 1'b1;
                  ram_raddr = cell_addr(row_sat, col_sat);
                  state_in  = S_READ;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_READ: begin
            cell_in  = ram_rdata;
            state_in = S_DONE;
         end
         S_BLANK: begin
            ram_we    = 1'b1;
            ram_wdata = {item_attr, cfg.fill_char};
            col_in    = next_col;
            if (next_col == CW'(COLUMNS) || (tab_ff && TAB_STOPS[next_col])) begin
               state_in = S_WRAP;
            end
         end
         S_BACK: begin
            ram_we    = 1'b1;
            ram_wdata = {cfg.fill_attr, cfg.fill_char};
            state_in  = S_DONE;
         end
         S_WRAP: begin
            state_in = S_DONE;
            if (col_ff == CW'(COLUMNS)) begin
               col_in = '0;
               if (line_ff < RW'(ROWS - 1)) begin
                  line_in = RW'(line_ff + 1'b1);
               end else begin
                  idx_in   = '0;
                  state_in = S_SCR_RD;
               end
            end
         end
         S_SCR_RD: begin
            ram_re    = 1'b1;
            ram_raddr = AW'(idx_ff + AW'(COLUMNS));
            state_in  = S_SCR_WR;
         end
         S_SCR_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = ram_rdata;
            idx_in    = AW'(idx_ff + 1'b1);
            state_in  = (idx_ff == AW'(CELLS - COLUMNS - 1)) ? S_FILL : S_SCR_RD;
         end
         S_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = {cfg.fill_attr, cfg.fill_char};
            idx_in    = AW'(idx_ff + 1'b1);
            if (idx_ff == AW'(CELLS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         col_ff   <= '0;
         line_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         line_ff  <= line_in;
         idx_ff   <= idx_in;
      end
      item_ff <= item_in;
      tab_ff  <= tab_in;
      cell_ff <= cell_in;
   end

   assign rsp.cursor_col     = 7'(col_ff);
   assign rsp.cursor_row     = 5'(line_ff);
   assign rsp.cursor_address = 11'(cur_addr);
   assign rsp.cell_char      = cell_ff[7:0];
   assign rsp.cell_attr      = cell_ff[15:8];

endmodule
`default_nettype wire

@@ rtl/text_console_char_writer_unit.sv @@
// Top level of the text console character writer: ports, configuration and result register.
// One item at a time: a newline or tab blanks cells with the fill character, and a wrap past the
// last row scrolls the store up by one row and fills the bottom row. A stalled result holds the
// sequencer, and the next item is taken in the cycle after the result is registered.
// Reset is synchronous; afterwards a clearing pass zeroes the store.
`default_nettype none
module text_console_char_writer_unit #(
   parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS     = tcw_pkg::DEF_ROWS,
   parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // ch, fg, bg, col, row, zero pad
   input  wire logic [tcw_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // cmd
   input  wire logic [tcw_pkg::CMD_W-1:0]        req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // cursor_col, cursor_row, cursor_address, cell_char, cell_attr, zero pad
   output logic [tcw_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [tcw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tcw_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   logic [7:0]             fill_char_ff;
   logic [7:0]             fill_attr_ff;
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   req_type           req;
   cfg_type           cfg;
   rsp_type           seq_rsp;
   logic              seq_rsp_valid;
   logic              out_free;
   logic              ram_we;
   logic              ram_re;
   logic [AW-1:0]     ram_waddr;
   logic [AW-1:0]     ram_raddr;
   logic [CELL_W-1:0] ram_wdata;
   logic [CELL_W-1:0] ram_rdata;

   assign req.cmd = req_tuser;
   assign req.ch  = req_tdata[7:0];
   assign req.fg  = req_tdata[11:8];
   assign req.bg  = req_tdata[15:12];
   assign req.col = req_tdata[22:16];
   assign req.row = req_tdata[27:23];

   assign cfg.fill_char = fill_char_ff;
   assign cfg.fill_attr = fill_attr_ff;
   assign out_free      = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_char_ff <= FILL_CHAR_RESET;
         fill_attr_ff <= FILL_ATTR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FILL_CHAR: fill_char_ff <= csr_wdata;
            CSR_FILL_ATTR: fill_attr_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_rsp_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (seq_rsp_valid) begin
         rsp_data_ff <= {1'b0, seq_rsp.cell_attr, seq_rsp.cell_char, seq_rsp.cursor_address,
                         seq_rsp.cursor_row, seq_rsp.cursor_col};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   tcw_seq #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP),
      .AW       (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .cfg       (cfg),
      .out_free  (out_free),
      .rsp_valid (seq_rsp_valid),
      .rsp       (seq_rsp),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule
`default_nettype wire

@@ rtl/tcw_checker.sv @@
// Port-level checks of the text console character writer and their binding.
`default_nettype none
module tcw_checker #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [tcw_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import tcw_pkg::*;

   logic [10:0] expected_address;

   assign expected_address = 11'(32'(rsp_tdata[11:7]) * 32'(COLUMNS) + 32'(rsp_tdata[6:0]));

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while another is in progress");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[6:0]) < COLUMNS) && (32'(rsp_tdata[11:7]) < ROWS))
      else $error("cursor outside the screen");

   a_cursor_address: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:12] == expected_address)
      else $error("cursor address does not match row and column");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

endmodule

bind text_console_char_writer_unit tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_checker (.*);
`default_nettype wire

@@ sim/tcw_screen_checker.sv @@
// Screen checker: tracks cells, cursor and blank registers, predicts each result and compares.
module tcw_screen_checker #(
   parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS     = tcw_pkg::DEF_ROWS,
   parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   // ch, fg, bg, col, row, zero pad
   input  wire logic [tcw_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // cmd
   input  wire logic [tcw_pkg::CMD_W-1:0]        req_tuser,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // cursor_col, cursor_row, cursor_address, cell_char, cell_attr, zero pad
   input  wire logic [tcw_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [tcw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tcw_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                    failures,
   output int                                    pending
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] screen [COLUMNS*ROWS];
   int unsigned       cur_col;
   int unsigned       cur_row;
   logic [7:0]        blank_ch;
   logic [7:0]        blank_at;
   rsp_type           due_reports [$];
   rsp_type           want;
   rsp_type           got;

   function automatic void blank_run(input int unsigned stop, input logic [7:0] attr);
      while (cur_col < stop) begin
         screen[cur_row*COLUMNS + cur_col] = {attr, blank_ch};
         cur_col++;
      end
   endfunction

   function automatic void scroll_screen();
      for (int i = 0; i < COLUMNS*(ROWS-1); i++) begin
         screen[i] = screen[i+COLUMNS];
      end
      for (int i = 0; i < COLUMNS; i++) begin
         screen[COLUMNS*(ROWS-1) + i] = {blank_at, blank_ch};
      end
   endfunction

   function automatic void put_char(input logic [7:0] ch, input logic [7:0] attr);
      int unsigned stop;
      case (ch)
         CH_RETURN: cur_col = 0;
         CH_NEWLINE: blank_run(COLUMNS, attr);
         CH_TAB: begin
            stop = cur_col + TAB_STOP - cur_col % TAB_STOP;
            if (stop > COLUMNS) stop = COLUMNS;
            blank_run(stop, attr);
         end
         CH_BACKSPACE: begin
            if (cur_col != 0 || cur_row != 0) begin
               if (cur_col == 0) begin
                  cur_col = COLUMNS - 1;
                  cur_row--;
               end else begin
                  cur_col--;
               end
               screen[cur_row*COLUMNS + cur_col] = {blank_at, blank_ch};
            end
         end
         default: begin
            screen[cur_row*COLUMNS + cur_col] = {attr, ch};
            cur_col++;
         end
      endcase
      if (cur_col >= COLUMNS) begin
         cur_col = 0;
         if (cur_row < ROWS - 1) cur_row++;
         else scroll_screen();
      end
   endfunction

   function automatic rsp_type predict_report(input logic [CMD_W-1:0] cmd, input logic [7:0] ch,
                                              input logic [3:0] fg, input logic [3:0] bg,
                                              input logic [6:0] col, input logic [4:0] row);
      rsp_type           r;
      int unsigned       c;
      int unsigned       w;
      logic [CELL_W-1:0] stored;
      c = (col > COLUMNS - 1) ? COLUMNS - 1 : col;
      w = (row > ROWS - 1) ? ROWS - 1 : row;
      r = '0;
      case (cmd)
         CMD_PRINT: put_char(ch, {bg, fg});
         CMD_SET_CURSOR: begin
            cur_col = c;
            cur_row = w;
         end
         CMD_READ_CELL: begin
            stored = screen[w*COLUMNS + c];
            r.cell_char = stored[7:0];
            r.cell_attr = stored[15:8];
         end
         default: ;
      endcase
      r.cursor_col     = 7'(cur_col);
      r.cursor_row     = 5'(cur_row);
      r.cursor_address = 11'(cur_row*COLUMNS + cur_col);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COLUMNS*ROWS; i++) begin
            screen[i] = '0;
         end
         cur_col  = 0;
         cur_row  = 0;
         blank_ch = FILL_CHAR_RESET;
         blank_at = FILL_ATTR_RESET;
         due_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FILL_CHAR: blank_ch = csr_wdata;
               CSR_FILL_ATTR: blank_at = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.cursor_col     = rsp_tdata[6:0];
            got.cursor_row     = rsp_tdata[11:7];
            got.cursor_address = rsp_tdata[22:12];
            got.cell_char      = rsp_tdata[30:23];
            got.cell_attr      = rsp_tdata[38:31];
            if (due_reports.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("result with no item waiting: tdata %h", rsp_tdata);
            end else begin
               want = due_reports.pop_front();
               if (want != got) begin
                  failures++;
                  if (failures <= 10)
                     $display({"result mismatch: col %0d/%0d row %0d/%0d addr %0d/%0d",
                               " char %h/%h attr %h/%h"},
                              want.cursor_col, got.cursor_col, want.cursor_row, got.cursor_row,
                              want.cursor_address, got.cursor_address,
                              want.cell_char, got.cell_char, want.cell_attr, got.cell_attr);
               end
            end
         end
         if (req_tvalid && req_tready)
            due_reports.push_back(predict_report(req_tuser, req_tdata[7:0], req_tdata[11:8],
                                                 req_tdata[15:12], req_tdata[22:16],
                                                 req_tdata[27:23]));
      end
      pending <= due_reports.size();
   end

endmodule

@@ sim/testbench.sv @@
// Bench top for the text console writer: clock, reset, register writes, item stimulus and verdict.
module testbench;
   import tcw_pkg::*;

   localparam int COLUMNS     = DEF_COLUMNS;
   localparam int ROWS        = DEF_ROWS;
   localparam int TAB_STOP    = DEF_TAB_STOP;
   localparam int CYCLE_LIMIT = 3000000;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]       req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   int                     failures;
   int                     pending;
   int                     send_idle_pct = 12;
   int                     recv_idle_pct = 46;
   int                     cycles = 0;

   text_console_char_writer_unit #(
      .COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_STOP(TAB_STOP)
   ) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   tcw_screen_checker #(
      .COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_STOP(TAB_STOP)
   ) screen_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL text_console_char_writer_unit");
         $finish;
      end
   end

   task automatic send_item(input logic [CMD_W-1:0] op, input logic [7:0] ch,
                            input logic [3:0] fg, input logic [3:0] bg,
                            input logic [6:0] col, input logic [4:0] row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, row, col, bg, fg, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_blanks(input logic [7:0] ch, input logic [7:0] attr);
      csr_we    <= 1'b1;
      csr_index <= CSR_FILL_CHAR;
      csr_wdata <= ch;
      @(posedge clock);
      csr_index <= CSR_FILL_ATTR;
      csr_wdata <= attr;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [7:0] text_char();
      case ($urandom_range(9))
         0: return CH_NEWLINE;
         1: return CH_TAB;
         2: return CH_BACKSPACE;
         3: return CH_RETURN;
         4: return 8'($urandom);
         default: return 8'($urandom_range(126, 32));
      endcase
   endfunction

   task automatic run_directed();
      send_item(CMD_READ_CELL, 8'h00, 4'h0, 4'h0, 7'd0, 5'd0);
      send_item(CMD_PRINT, 8'h41, 4'hF, 4'hF, 7'd0, 5'd0);
      send_item(CMD_PRINT, CH_BACKSPACE, 4'h1, 4'h2, 7'd0, 5'd0);
      send_item(CMD_PRINT, CH_BACKSPACE, 4'h1, 4'h2, 7'd0, 5'd0);
      send_item(CMD_PRINT, 8'h00, 4'h0, 4'h0, 7'd0, 5'd0);
      send_item(CMD_PRINT, 8'hFF, 4'hA, 4'h5, 7'h7F, 5'h1F);
      send_item(CMD_PRINT, CH_TAB, 4'h3, 4'hC, 7'd0, 5'd0);
      send_item(CMD_READ_CELL, 8'h00, 4'h0, 4'h0, 7'd5, 5'd0);
      send_item(CMD_PRINT, CH_RETURN, 4'h0, 4'h0, 7'd0, 5'd0);
      send_item(CMD_SET_CURSOR, 8'h00, 4'h0, 4'h0, 7'h7F, 5'h1F);
      send_item(CMD_READ_CELL, 8'h00, 4'h0, 4'h0, 7'h7F, 5'h1F);
      send_item(CMD_PRINT, 8'h7E, 4'hE, 4'h1, 7'd0, 5'd0);
      send_item(CMD_READ_CELL, 8'h00, 4'h0, 4'h0, 7'd79, 5'd23);
      send_item(CMD_SET_CURSOR, 8'h00, 4'h0, 4'h0, 7'd76, 5'd3);
      send_item(CMD_PRINT, CH_TAB, 4'h6, 4'h9, 7'd0, 5'd0);
      send_item(CMD_SET_CURSOR, 8'h00, 4'h0, 4'h0, 7'd0, 5'd5);
      send_item(CMD_PRINT, CH_BACKSPACE, 4'h7, 4'h8, 7'd0, 5'd0);
      send_item(CMD_READ_CELL, 8'h00, 4'h0, 4'h0, 7'd79, 5'd4);
      send_item(CMD_SET_CURSOR, 8'h00, 4'h0, 4'h0, 7'd10, 5'd24);
      send_item(CMD_PRINT, CH_NEWLINE, 4'h2, 4'h4, 7'd0, 5'd0);
      send_item(CMD_READ_CELL, 8'h00, 4'h0, 4'h0, 7'd12, 5'd23);
      send_item(CMD_READ_CELL, 8'h00, 4'h0, 4'h0, 7'd40, 5'd24);
      send_item(CMD_UNUSED, 8'hFF, 4'hF, 4'hF, 7'h7F, 5'h1F);
      send_item(CMD_SET_CURSOR, 8'hFF, 4'hF, 4'hF, 7'd0, 5'd0);
   endtask

   task automatic random_traffic(input int target);
      int         sent;
      int         len;
      logic [6:0] c;
      logic [4:0] r;
      logic [3:0] fg;
      logic [3:0] bg;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(99) < 60) begin
            c  = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(COLUMNS - 1));
            r  = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(ROWS - 1));
            fg = 4'($urandom);
            bg = 4'($urandom);
            len = $urandom_range(6, 2);
            send_item(CMD_SET_CURSOR, 8'($urandom), 4'($urandom), 4'($urandom), c, r);
            for (int k = 0; k < len; k++) begin
               send_item(CMD_PRINT, text_char(), fg, bg, 7'($urandom), 5'($urandom));
            end
            send_item(CMD_READ_CELL, 8'($urandom), 4'($urandom), 4'($urandom), c, r);
            sent += len + 2;
         end else begin
            send_item(2'($urandom), 8'($urandom), 4'($urandom), 4'($urandom),
                      7'($urandom), 5'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      settle();
      set_blanks(8'h00, 8'hFF);
      random_traffic(38);
      settle();
      send_idle_pct <= 46;
      recv_idle_pct <= 12;
      set_blanks(8'hFF, 8'h00);
      random_traffic(38);
      settle();
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      set_blanks(8'($urandom), 8'($urandom));
      random_traffic(38);
      settle();
      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("PASS text_console_char_writer_unit");
      end else begin
         $display("FAIL text_console_char_writer_unit");
      end
      $finish;
   end

endmodule

@@ text_console_char_writer_unit.f @@
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_seq.sv
rtl/text_console_char_writer_unit.sv
rtl/tcw_checker.sv
sim/tcw_screen_checker.sv
sim/testbench.sv
